// ----- rtl/rotate_vector_3d_axis_defines.svh -----
// Assertion macros shared by the rotate_vector_3d_axis RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ROTATE_VECTOR_3D_AXIS_DEFINES_SVH
`define ROTATE_VECTOR_3D_AXIS_DEFINES_SVH

// Same-cycle implication.
`define RVA3_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RVA3_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rva3_pkg.sv -----
// Shared types, constants and the CORDIC gain function for rotate_vector_3d_axis.
// No dependencies.
package rva3_pkg;

	localparam int SINE_ITERATIONS_DEF = 16;
	localparam int ATAN_ENTRIES = 24;

	// Widths of the Q2.30 CORDIC datapath.
	localparam int CW = 34;
	localparam int ZW = 36;

	localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [CW:0]   ONE_Q30     = 35'sd1073741824;
	localparam logic signed [31:0]   ONE_Q26     = 32'sd67108864;
	localparam logic signed [31:0]   OUT_MAX     = 32'sh7fffffff;
	localparam logic signed [31:0]   OUT_MIN     = 32'sh80000000;

	localparam logic [1:0] MODE_X    = 2'd0;
	localparam logic [1:0] MODE_Y    = 2'd1;
	localparam logic [1:0] MODE_Z    = 2'd2;
	localparam logic [1:0] MODE_AXIS = 2'd3;

	localparam logic [31:0] ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
		32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
		32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
	};

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] angle;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} item_t;

	// Row-major 3x3 matrix of Q26 coefficients.
	typedef logic [8:0][31:0] mat_t;

	// Starting x of the CORDIC: inverse gain of n micro-rotations, Q2.30.
	function automatic logic [63:0] cordic_gain(input int n);
		logic [127:0] p;
		logic [127:0] rem;
		logic [63:0]  q;
		logic [63:0]  num;
		logic [63:0]  res;
		logic [63:0]  bt;
		int           i;
		p = 128'd1 << 30;
		for (i = 0; i < ATAN_ENTRIES; i++) begin
			if (i < n) begin
				p = (p * ((128'd1 << 30) + ((128'd1 << 30) >> (2 * i)))) >> 30;
			end
		end
		rem = '0;
		q = '0;
		for (i = 60; i >= 0; i--) begin
			rem = (rem << 1) | ((i == 60) ? 128'd1 : 128'd0);
			if (rem >= p) begin
				rem = rem - p;
				q[i] = 1'b1;
			end
		end
		num = q << 30;
		res = '0;
		bt = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (bt > num) begin
				bt = bt >> 2;
			end
		end
		for (i = 0; i < 32; i++) begin
			if (bt != 0) begin
				if (num >= res + bt) begin
					num = num - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/rva3_cordic.sv -----
// Angle range reduction and pipelined rotation-mode CORDIC, one micro-rotation per stage.
// Depends on rva3_pkg and rotate_vector_3d_axis_defines.svh.
`include "rotate_vector_3d_axis_defines.svh"

module rva3_cordic #(
	parameter int SINE_ITERATIONS = rva3_pkg::SINE_ITERATIONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  rva3_pkg::item_t               in_item,
	output logic                          out_valid,
	output rva3_pkg::item_t               out_item,
	output logic signed [rva3_pkg::CW-1:0] cos_val,
	output logic signed [rva3_pkg::CW-1:0] sin_val
);

	localparam int N = SINE_ITERATIONS;
	localparam logic [63:0] GAIN = rva3_pkg::cordic_gain(N);

	logic                            wrap_vld_s1;
	rva3_pkg::item_t                 wrap_item_s1;
	logic signed [rva3_pkg::ZW-1:0]  wrap_s1;
	logic signed [rva3_pkg::ZW-1:0]  ang_raw;
	logic signed [rva3_pkg::ZW-1:0]  ang_wrap;
	logic signed [rva3_pkg::ZW-1:0]  ang_fold;
	logic                            fold_neg;
	logic                            fold_ok;

	logic                            vld_s  [0:N];
	rva3_pkg::item_t                 item_s [0:N];
	logic                            neg_s  [0:N];
	logic signed [rva3_pkg::CW-1:0]  cx_s   [0:N];
	logic signed [rva3_pkg::CW-1:0]  cy_s   [0:N];
	logic signed [rva3_pkg::ZW-1:0]  cz_s   [0:N];

	// Scale Q4.12 to Q2.30 and wrap once by a full turn.
	always_comb begin
		ang_raw = rva3_pkg::ZW'(in_item.angle) <<< 18;
		if (ang_raw > rva3_pkg::PI_Q30) begin
			ang_wrap = ang_raw - rva3_pkg::TWO_PI_Q30;
		end else if (ang_raw < -rva3_pkg::PI_Q30) begin
			ang_wrap = ang_raw + rva3_pkg::TWO_PI_Q30;
		end else begin
			ang_wrap = ang_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_vld_s1 <= 1'b0;
		end else if (en) begin
			wrap_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wrap_s1 <= ang_wrap;
			wrap_item_s1 <= in_item;
		end
	end

	// Fold into the right half plane; the result is negated at the end.
	always_comb begin
		if (wrap_s1 > rva3_pkg::HALF_PI_Q30) begin
			ang_fold = wrap_s1 - rva3_pkg::PI_Q30;
			fold_neg = 1'b1;
		end else if (wrap_s1 < -rva3_pkg::HALF_PI_Q30) begin
			ang_fold = wrap_s1 + rva3_pkg::PI_Q30;
			fold_neg = 1'b1;
		end else begin
			ang_fold = wrap_s1;
			fold_neg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= wrap_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= wrap_item_s1;
			neg_s[0] <= fold_neg;
			cx_s[0] <= rva3_pkg::CW'(GAIN);
			cy_s[0] <= '0;
			cz_s[0] <= ang_fold;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam logic signed [rva3_pkg::ZW-1:0] ATAN_I =
			rva3_pkg::ZW'(rva3_pkg::ATAN_Q30[i]);
		logic signed [rva3_pkg::CW-1:0] dx;
		logic signed [rva3_pkg::CW-1:0] dy;

		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[i+1] <= item_s[i];
				neg_s[i+1] <= neg_s[i];
				if (!cz_s[i][rva3_pkg::ZW-1]) begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - ATAN_I;
				end else begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + ATAN_I;
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_item  = item_s[N];
	assign cos_val   = neg_s[N] ? -cx_s[N] : cx_s[N];
	assign sin_val   = neg_s[N] ? -cy_s[N] : cy_s[N];

	assign fold_ok = (cz_s[0] <= rva3_pkg::HALF_PI_Q30) && (cz_s[0] >= -rva3_pkg::HALF_PI_Q30);

	`RVA3_ASSERT_IMP(a_fold_in_range, vld_s[0], fold_ok, "folded angle outside half turn")

endmodule

// ----- rtl/rva3_matrix.sv -----
// Builds the Q26 rotation matrix from cosine, sine, mode and axis in three stages.
// Depends on rva3_pkg.
module rva3_matrix (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  rva3_pkg::item_t               in_item,
	input  logic signed [rva3_pkg::CW-1:0] cos_val,
	input  logic signed [rva3_pkg::CW-1:0] sin_val,
	output logic                          out_valid,
	output rva3_pkg::item_t               out_item,
	output rva3_pkg::mat_t                mat
);

	logic signed [15:0] ax [0:2];

	logic                             vld_s1, vld_s2, vld_s3;
	rva3_pkg::item_t                  item_s1, item_s2, item_s3;
	logic signed [rva3_pkg::CW-1:0]   c_s1, c_s2;
	logic signed [rva3_pkg::CW:0]     u_s1;
	logic signed [31:0]               aa_s1 [0:8];
	logic signed [49:0]               sa_s1 [0:2];
	logic signed [49:0]               sa_s2 [0:2];
	logic signed [31:0]               c26_s1, c26_s2, s26_s1, s26_s2;
	logic signed [66:0]               uaa_s2 [0:8];
	rva3_pkg::mat_t                   m_s3;
	rva3_pkg::mat_t                   m_next;

	logic signed [rva3_pkg::CW-1:0]   c_rnd, s_rnd;

	assign ax[0] = in_item.axis_x;
	assign ax[1] = in_item.axis_y;
	assign ax[2] = in_item.axis_z;
	assign c_rnd = (cos_val + rva3_pkg::CW'(8)) >>> 4;
	assign s_rnd = (sin_val + rva3_pkg::CW'(8)) >>> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Axis outer products and sine-axis terms.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			c_s1 <= cos_val;
			u_s1 <= rva3_pkg::ONE_Q30 - (rva3_pkg::CW+1)'(cos_val);
			c26_s1 <= 32'(c_rnd);
			s26_s1 <= 32'(s_rnd);
			for (int r = 0; r < 3; r++) begin
				sa_s1[r] <= 50'(sin_val) * 50'(ax[r]);
				for (int k = 0; k < 3; k++) begin
					aa_s1[r*3+k] <= 32'(ax[r]) * 32'(ax[k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_s1;
			c_s2 <= c_s1;
			c26_s2 <= c26_s1;
			s26_s2 <= s26_s1;
			sa_s2 <= sa_s1;
			for (int j = 0; j < 9; j++) begin
				uaa_s2[j] <= 67'(u_s1) * 67'(aa_s1[j]);
			end
		end
	end

	// Sum the Q58 terms, round to Q26, or pick the coordinate-axis matrix.
	always_comb begin
		logic signed [67:0] t;
		logic signed [67:0] diag;
		logic signed [67:0] sk [0:2];
		diag = 68'(c_s2) <<< 28;
		for (int j = 0; j < 3; j++) begin
			sk[j] = 68'(sa_s2[j]) <<< 14;
		end
		m_next = '0;
		case (item_s2.mode)
			rva3_pkg::MODE_X: begin
				m_next[0] = rva3_pkg::ONE_Q26;
				m_next[4] = c26_s2;
				m_next[8] = c26_s2;
				m_next[5] = -s26_s2;
				m_next[7] = s26_s2;
			end
			rva3_pkg::MODE_Y: begin
				m_next[4] = rva3_pkg::ONE_Q26;
				m_next[0] = c26_s2;
				m_next[8] = c26_s2;
				m_next[2] = s26_s2;
				m_next[6] = -s26_s2;
			end
			rva3_pkg::MODE_Z: begin
				m_next[8] = rva3_pkg::ONE_Q26;
				m_next[0] = c26_s2;
				m_next[4] = c26_s2;
				m_next[1] = -s26_s2;
				m_next[3] = s26_s2;
			end
			default: begin
				for (int r = 0; r < 3; r++) begin
					for (int k = 0; k < 3; k++) begin
						t = 68'(uaa_s2[r*3+k]) + (68'sd1 <<< 31);
						if (r == k) t = t + diag;
						if (r == 0 && k == 1) t = t - sk[2];
						if (r == 1 && k == 0) t = t + sk[2];
						if (r == 0 && k == 2) t = t + sk[1];
						if (r == 2 && k == 0) t = t - sk[1];
						if (r == 1 && k == 2) t = t - sk[0];
						if (r == 2 && k == 1) t = t + sk[0];
						m_next[r*3+k] = t[63:32];
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= item_s2;
			m_s3 <= m_next;
		end
	end

	assign out_valid = vld_s3;
	assign out_item  = item_s3;
	assign mat       = m_s3;

endmodule

// ----- rtl/rva3_apply.sv -----
// Multiplies the vector by the matrix, rounds to Q16.16 and saturates.
// Depends on rva3_pkg.
module rva3_apply (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  rva3_pkg::item_t    in_item,
	input  rva3_pkg::mat_t     mat,
	output logic               out_valid,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               saturated
);

	logic signed [31:0] v [0:2];
	logic               vld_s1, vld_s2;
	logic signed [63:0] p_s1 [0:8];
	logic signed [31:0] o_s2 [0:2];
	logic               sat_s2;
	logic signed [31:0] o_next [0:2];
	logic               sat_next;

	assign v[0] = in_item.vec_x;
	assign v[1] = in_item.vec_y;
	assign v[2] = in_item.vec_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				p_s1[j] <= 64'(v[j%3]) * 64'($signed(mat[j]));
			end
		end
	end

	always_comb begin
		logic signed [65:0] acc;
		logic signed [39:0] rnd;
		sat_next = 1'b0;
		for (int r = 0; r < 3; r++) begin
			acc = 66'(p_s1[r*3]) + 66'(p_s1[r*3+1]) + 66'(p_s1[r*3+2]) + (66'sd1 <<< 25);
			rnd = acc[65:26];
			if (rnd > 40'(rva3_pkg::OUT_MAX)) begin
				o_next[r] = rva3_pkg::OUT_MAX;
				sat_next = 1'b1;
			end else if (rnd < 40'(rva3_pkg::OUT_MIN)) begin
				o_next[r] = rva3_pkg::OUT_MIN;
				sat_next = 1'b1;
			end else begin
				o_next[r] = rnd[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s2 <= o_next;
			sat_s2 <= sat_next;
		end
	end

	assign out_valid = vld_s2;
	assign out_x     = o_s2[0];
	assign out_y     = o_s2[1];
	assign out_z     = o_s2[2];
	assign saturated = sat_s2;

endmodule

// ----- rtl/rotate_vector_3d_axis.sv -----
// Top level of rotate_vector_3d_axis: vector rotation about X, Y, Z or a given axis.
// Depends on rva3_pkg, rva3_cordic, rva3_matrix, rva3_apply and the defines header.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  input   | vec_valid / vec_ready  | mode, angle, vec_x/y/z, axis_x/y/z
//  output  | res_valid / res_ready  | out_x, out_y, out_z, saturated
//
// One request enters per cycle while vec_ready is high; each passes the wrap and fold
// stages, the CORDIC chain (one micro-rotation per stage), matrix and product stages.
// Reset clears only the stage valid bits; payload registers are not reset.
// When a result waits and res_ready is low, every stage holds and vec_ready drops.
`include "rotate_vector_3d_axis_defines.svh"

module rotate_vector_3d_axis #(
	parameter int SINE_ITERATIONS = rva3_pkg::SINE_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vec_valid,
	output logic               vec_ready,
	input  logic [1:0]         mode,
	input  logic signed [15:0] angle,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               saturated
);

	logic                            en;
	rva3_pkg::item_t                 item_in;
	logic                            cor_valid;
	rva3_pkg::item_t                 cor_item;
	logic signed [rva3_pkg::CW-1:0]  cos_val, sin_val;
	logic                            mat_valid;
	rva3_pkg::item_t                 mat_item;
	rva3_pkg::mat_t                  mat;
	logic                            out_clipped;

	assign en = !res_valid || res_ready;
	assign vec_ready = en;

	assign item_in = '{mode: mode, angle: angle, vec_x: vec_x, vec_y: vec_y, vec_z: vec_z,
		axis_x: axis_x, axis_y: axis_y, axis_z: axis_z};

	rva3_cordic #(
		.SINE_ITERATIONS(SINE_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vec_valid),
		.in_item(item_in),
		.out_valid(cor_valid),
		.out_item(cor_item),
		.cos_val(cos_val),
		.sin_val(sin_val)
	);

	rva3_matrix u_matrix (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(cor_valid),
		.in_item(cor_item),
		.cos_val(cos_val),
		.sin_val(sin_val),
		.out_valid(mat_valid),
		.out_item(mat_item),
		.mat(mat)
	);

	rva3_apply u_apply (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(mat_valid),
		.in_item(mat_item),
		.mat(mat),
		.out_valid(res_valid),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.saturated(saturated)
	);

	assign out_clipped = (out_x == rva3_pkg::OUT_MAX) || (out_x == rva3_pkg::OUT_MIN) ||
		(out_y == rva3_pkg::OUT_MAX) || (out_y == rva3_pkg::OUT_MIN) ||
		(out_z == rva3_pkg::OUT_MAX) || (out_z == rva3_pkg::OUT_MIN);

	`RVA3_ASSERT_IMP(a_sat_at_limit, res_valid && saturated, out_clipped, "saturated flag without a clipped component")
	`RVA3_ASSERT_IMP(a_stall_blocks_input, res_valid && !res_ready, !vec_ready, "input taken while output stalled")

endmodule
